// ===== hw/rtl/mrcs_pkg.sv =====
// Shared constants and types for the matrix row/column sum argmax block.
// No dependencies; mrcs_res_if, mrcs_best, matrix_max_row_col_sum and mrcs_checker use this package.
package mrcs_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int MAX_DIM_DEF    = 16;
    localparam int ELEM_WIDTH_DEF = 16;

    // Configuration port.
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 5'd16;

    // Widths of the result word fields.
    localparam int IDX_OUT_W = 4;
    localparam int SUM_OUT_W = 20;

    // Position flags of one element within the matrix.
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_row;
        logic last_col;
    } t_pos_flags;

endpackage

// ===== hw/rtl/mrcs_elem_if.sv =====
// Valid/ready channel carrying one matrix element per word.
// Depends on nothing; the element width is a parameter.
interface mrcs_elem_if #(
    parameter int ELEM_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] elem_value;

    modport source (output valid, output elem_value, input ready);
    modport sink   (input valid, input elem_value, output ready);
endinterface

// ===== hw/rtl/mrcs_res_if.sv =====
// Valid/ready channel carrying one argmax result word.
// Depends on mrcs_pkg for the field widths.
interface mrcs_res_if;
    logic                                   valid;
    logic                                   ready;
    logic        [mrcs_pkg::IDX_OUT_W-1:0]  best_row_index;
    logic signed [mrcs_pkg::SUM_OUT_W-1:0]  best_row_sum;
    logic        [mrcs_pkg::IDX_OUT_W-1:0]  best_col_index;
    logic signed [mrcs_pkg::SUM_OUT_W-1:0]  best_col_sum;

    modport source (output valid, output best_row_index, output best_row_sum,
                    output best_col_index, output best_col_sum, input ready);
    modport sink   (input valid, input best_row_index, input best_row_sum,
                    input best_col_index, input best_col_sum, output ready);
endinterface

// ===== hw/rtl/mrcs_colmem.sv =====
// Column sum memory: one write port, one read port with registered data.
// A write to the entry being read at the same edge is bypassed to the read data.
// Depends on nothing.
module mrcs_colmem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 20,
    parameter int AW    = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [WIDTH-1:0] i_wr_data,
    output logic signed [WIDTH-1:0] o_rd_data
);

    logic signed [WIDTH-1:0] r_mem [DEPTH];
    logic signed [WIDTH-1:0] r_rd_q;
    logic signed [WIDTH-1:0] r_byp_data;
    logic                    r_byp;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, catching a write to the same entry at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q     <= r_mem[i_rd_addr];
            r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_q;

endmodule

// ===== hw/rtl/mrcs_best.sv =====
// Row accumulator, best row and column tracking, and the result word register.
// Depends on mrcs_pkg for the flag struct and result field widths.
module mrcs_best #(
    parameter int ELEM_WIDTH = 16,
    parameter int SUM_W      = 20,
    parameter int IDX_W      = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  mrcs_pkg::t_pos_flags                   i_flags,
    input  logic        [IDX_W-1:0]                i_row,
    input  logic        [IDX_W-1:0]                i_col,
    input  logic signed [ELEM_WIDTH-1:0]           i_elem,
    input  logic signed [SUM_W-1:0]                i_col_prev,
    output logic signed [SUM_W-1:0]                o_col_sum,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic        [mrcs_pkg::IDX_OUT_W-1:0]  o_row_index,
    output logic signed [mrcs_pkg::SUM_OUT_W-1:0]  o_row_sum,
    output logic        [mrcs_pkg::IDX_OUT_W-1:0]  o_col_index,
    output logic signed [mrcs_pkg::SUM_OUT_W-1:0]  o_col_best
);

    logic signed [SUM_W-1:0] w_elem;
    logic signed [SUM_W-1:0] w_row_sum;
    logic signed [SUM_W-1:0] r_row_acc;
    logic signed [SUM_W-1:0] r_top_row_sum;
    logic signed [SUM_W-1:0] n_top_row_sum;
    logic        [IDX_W-1:0] r_top_row_idx;
    logic        [IDX_W-1:0] n_top_row_idx;
    logic signed [SUM_W-1:0] r_top_col_sum;
    logic signed [SUM_W-1:0] n_top_col_sum;
    logic        [IDX_W-1:0] r_top_col_idx;
    logic        [IDX_W-1:0] n_top_col_idx;
    logic                    r_out_valid;

    // New column and row sums; the first row and first column start afresh.
    assign w_elem    = SUM_W'(i_elem);
    assign o_col_sum = (i_flags.first_row ? '0 : i_col_prev) + w_elem;
    assign w_row_sum = (i_flags.first_col ? '0 : r_row_acc) + w_elem;

    // Best candidates: the first always wins, later ones only when strictly larger.
    always_comb begin
        n_top_row_sum = r_top_row_sum;
        n_top_row_idx = r_top_row_idx;
        n_top_col_sum = r_top_col_sum;
        n_top_col_idx = r_top_col_idx;
        if (i_flags.last_col && (i_flags.first_row || (w_row_sum > r_top_row_sum))) begin
            n_top_row_sum = w_row_sum;
            n_top_row_idx = i_row;
        end
        if (i_flags.last_row && (i_flags.first_col || (o_col_sum > r_top_col_sum))) begin
            n_top_col_sum = o_col_sum;
            n_top_col_idx = i_col;
        end
    end

    // Tracking registers advance with each element that leaves the read stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row_acc     <= w_row_sum;
            r_top_row_sum <= n_top_row_sum;
            r_top_row_idx <= n_top_row_idx;
            r_top_col_sum <= n_top_col_sum;
            r_top_col_idx <= n_top_col_idx;
        end
    end

    // Result word register, loaded by the last element of the matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en && i_flags.last_row && i_flags.last_col) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_flags.last_row && i_flags.last_col) begin
            o_row_index <= mrcs_pkg::IDX_OUT_W'(n_top_row_idx);
            o_row_sum   <= mrcs_pkg::SUM_OUT_W'(n_top_row_sum);
            o_col_index <= mrcs_pkg::IDX_OUT_W'(n_top_col_idx);
            o_col_best  <= mrcs_pkg::SUM_OUT_W'(n_top_col_sum);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/matrix_max_row_col_sum.sv =====
// Streams a matrix in row-major order, one element word per clock, and returns one result word
// per matrix holding the index and sum of the largest row and the largest column (lowest index
// on ties). The column sums live in a single memory with a registered read: an element reads its
// column's entry when accepted, then adds, compares and writes it back from the read stage
// register, with a bypass when consecutive elements share a column. Throughput is one element
// per cycle while the input is not stalled; the result word is loaded as the last element leaves
// the read stage and is held in an output register, so input only stalls when a finished result
// waits and the next result is ready. Dimensions of 0 act as 1 and values above MAX_DIM as
// MAX_DIM; a write to either size register starts a new matrix, while a write to an unused index
// is ignored. The memory needs no clearing pass after reset.
module matrix_max_row_col_sum #(
    parameter int MAX_DIM    = mrcs_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mrcs_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mrcs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mrcs_pkg::CFG_W-1:0]        i_cfg_data,
    mrcs_elem_if.sink                         i_elem,
    mrcs_res_if.source                        o_res
);

    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SUM_W   = ELEM_WIDTH + $clog2(MAX_DIM);
    localparam int DIM_CAP = (MAX_DIM < 31) ? MAX_DIM : 31;

    logic [mrcs_pkg::CFG_W-1:0] r_num_rows;
    logic [mrcs_pkg::CFG_W-1:0] r_num_cols;
    logic [mrcs_pkg::CFG_W-1:0] w_rows;
    logic [mrcs_pkg::CFG_W-1:0] w_cols;
    logic [IDX_W-1:0]           r_col;
    logic [IDX_W-1:0]           r_row;
    mrcs_pkg::t_pos_flags       w_flags;
    logic                       w_accept;
    logic                       w_advance;
    logic                       w_cfg_hit;

    logic                         r_s1_valid;
    mrcs_pkg::t_pos_flags         r_s1_flags;
    logic [IDX_W-1:0]             r_s1_row;
    logic [IDX_W-1:0]             r_s1_col;
    logic signed [ELEM_WIDTH-1:0] r_s1_elem;

    logic signed [SUM_W-1:0] w_col_prev;
    logic signed [SUM_W-1:0] w_col_sum;
    logic                    w_out_valid;

    // Effective dimensions after clamping.
    assign w_rows = (r_num_rows == '0) ? mrcs_pkg::CFG_W'(1) :
                    (32'(r_num_rows) > DIM_CAP) ? mrcs_pkg::CFG_W'(DIM_CAP) : r_num_rows;
    assign w_cols = (r_num_cols == '0) ? mrcs_pkg::CFG_W'(1) :
                    (32'(r_num_cols) > DIM_CAP) ? mrcs_pkg::CFG_W'(DIM_CAP) : r_num_cols;

    // Position of the element at the input.
    assign w_flags.first_row = (r_row == '0);
    assign w_flags.first_col = (r_col == '0);
    assign w_flags.last_row  = ((32'(r_row) + 32'd1) == 32'(w_rows));
    assign w_flags.last_col  = ((32'(r_col) + 32'd1) == 32'(w_cols));

    // The pipeline holds only when a finished matrix cannot enter a full output register.
    assign w_advance = !(r_s1_valid && r_s1_flags.last_row && r_s1_flags.last_col &&
                         w_out_valid && !o_res.ready);
    assign i_elem.ready = w_advance;
    assign w_accept     = i_elem.valid && w_advance;
    assign w_cfg_hit    = i_cfg_we && ((i_cfg_idx == mrcs_pkg::CFG_NUM_ROWS) ||
                                       (i_cfg_idx == mrcs_pkg::CFG_NUM_COLS));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= mrcs_pkg::CFG_DIM_RESET;
            r_num_cols <= mrcs_pkg::CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrcs_pkg::CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                mrcs_pkg::CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Row and column counters; a configuration write restarts the matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_flags.last_col) begin
                r_col <= '0;
                r_row <= w_flags.last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Read stage register: the element waits here for its column sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_flags <= w_flags;
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
            r_s1_elem  <= i_elem.elem_value;
        end
    end

    mrcs_colmem #(
        .DEPTH (MAX_DIM),
        .WIDTH (SUM_W),
        .AW    (IDX_W)
    ) u_colmem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .i_wr_en   (r_s1_valid && w_advance),
        .i_wr_addr (r_s1_col),
        .i_wr_data (w_col_sum),
        .o_rd_data (w_col_prev)
    );

    mrcs_best #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .SUM_W      (SUM_W),
        .IDX_W      (IDX_W)
    ) u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (r_s1_valid && w_advance),
        .i_flags     (r_s1_flags),
        .i_row       (r_s1_row),
        .i_col       (r_s1_col),
        .i_elem      (r_s1_elem),
        .i_col_prev  (w_col_prev),
        .o_col_sum   (w_col_sum),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .o_row_index (o_res.best_row_index),
        .o_row_sum   (o_res.best_row_sum),
        .o_col_index (o_res.best_col_index),
        .o_col_best  (o_res.best_col_sum)
    );

    assign o_res.valid = w_out_valid;

endmodule

// ===== hw/rtl/mrcs_checker.sv =====
// Port-level checks on the result channel of the matrix argmax block.
// Depends on mrcs_pkg; bound to matrix_max_row_col_sum at the end of this file.
module mrcs_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_res_valid,
    input logic                                   i_res_ready,
    input logic        [mrcs_pkg::IDX_OUT_W-1:0]  i_row_index,
    input logic signed [mrcs_pkg::SUM_OUT_W-1:0]  i_row_sum,
    input logic        [mrcs_pkg::IDX_OUT_W-1:0]  i_col_index,
    input logic signed [mrcs_pkg::SUM_OUT_W-1:0]  i_col_sum
);

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // A result word waiting for the sink is not withdrawn.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result word withdrawn before it was taken");

    // A result word waiting for the sink keeps its contents.
    a_word_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_row_index) && $stable(i_row_sum) &&
            $stable(i_col_index) && $stable(i_col_sum))
        else $error("result word changed while stalled");

endmodule

bind matrix_max_row_col_sum mrcs_checker u_mrcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_row_index (o_res.best_row_index),
    .i_row_sum   (o_res.best_row_sum),
    .i_col_index (o_res.best_col_index),
    .i_col_sum   (o_res.best_col_sum)
);

// ===== tb/matrix_max_row_col_sum_tb.sv =====
// Self-checking testbench for matrix_max_row_col_sum: streams matrices, predicts each argmax word.
// Depends on mrcs_pkg, mrcs_elem_if, mrcs_res_if and the matrix_max_row_col_sum RTL.
module matrix_max_row_col_sum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM      = mrcs_pkg::MAX_DIM_DEF;
    localparam int ELEM_W       = mrcs_pkg::ELEM_WIDTH_DEF;
    localparam int SETTLE       = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_ITEMS   = 450;
    localparam int LIMIT_CYCLES = 500000;

    // Register indexes that the block must ignore.
    localparam logic [mrcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [mrcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef enum {VAL_ANY, VAL_TINY, VAL_EXTREME, VAL_MIXED} t_fill;

    typedef struct packed {
        logic        [mrcs_pkg::IDX_OUT_W-1:0] row_index;
        logic signed [mrcs_pkg::SUM_OUT_W-1:0] row_sum;
        logic        [mrcs_pkg::IDX_OUT_W-1:0] col_index;
        logic signed [mrcs_pkg::SUM_OUT_W-1:0] col_sum;
    } t_argmax;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            cfg_we   = 1'b0;
    logic [mrcs_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [mrcs_pkg::CFG_W-1:0]      cfg_data = '0;

    logic                     src_valid = 1'b0;
    logic signed [ELEM_W-1:0] src_value = '0;
    logic                     rsp_ready = 1'b0;

    mrcs_elem_if #(.ELEM_WIDTH(ELEM_W)) elem_if ();
    mrcs_res_if                         res_if ();

    assign elem_if.valid      = src_valid;
    assign elem_if.elem_value = src_value;
    assign res_if.ready       = rsp_ready;

    matrix_max_row_col_sum u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_elem     (elem_if.sink),
        .o_res      (res_if.source)
    );

    always #1 i_clk = ~i_clk;

    // Words waiting to be sent and argmax words still owed by the block.
    logic signed [ELEM_W-1:0] elem_q[$];
    t_argmax                  argmax_q[$];

    int  n_queued    = 0;
    int  n_accepted  = 0;
    int  n_results   = 0;
    int  n_errors    = 0;
    int  n_cycles    = 0;
    bit  elem_taken  = 1'b0;
    bit  quiet       = 1'b0;
    bit  stall_req   = 1'b0;
    bit  stall_done  = 1'b0;
    int  stall_left  = 0;

    // Predictor state: configured sizes, running sums and the leaders so far.
    logic [mrcs_pkg::CFG_W-1:0] dim_rows;
    logic [mrcs_pkg::CFG_W-1:0] dim_cols;
    longint           col_total[MAX_DIM];
    longint           row_total;
    int               col_at;
    int               row_at;
    longint           lead_row_sum;
    int               lead_row_idx;
    longint           lead_col_sum;
    int               lead_col_idx;

    function automatic int clip_dim(input logic [mrcs_pkg::CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    function automatic void restart_matrix();
        foreach (col_total[k]) col_total[k] = 0;
        row_total    = 0;
        col_at       = 0;
        row_at       = 0;
        lead_row_sum = 0;
        lead_row_idx = 0;
        lead_col_sum = 0;
        lead_col_idx = 0;
    endfunction

    // Folds one element into the sums; on the last element of a matrix the
    // argmax word is queued and a fresh matrix begins.
    function automatic void track_element(input logic signed [ELEM_W-1:0] value);
        int      rows;
        int      cols;
        int      c;
        int      r;
        longint  v;
        t_argmax res;
        rows = clip_dim(dim_rows);
        cols = clip_dim(dim_cols);
        v    = value;
        if (col_at >= cols || row_at >= rows) restart_matrix();
        c = col_at;
        r = row_at;
        row_total += v;
        if (r == 0) col_total[c] = v;
        else col_total[c] += v;
        // Column sums are final during the last row; strictly larger wins.
        if (r + 1 == rows && (c == 0 || col_total[c] > lead_col_sum)) begin
            lead_col_sum = col_total[c];
            lead_col_idx = c;
        end
        if (c + 1 == cols) begin
            if (r == 0 || row_total > lead_row_sum) begin
                lead_row_sum = row_total;
                lead_row_idx = r;
            end
            row_total = 0;
            col_at    = 0;
            if (r + 1 == rows) begin
                res.row_index = mrcs_pkg::IDX_OUT_W'(lead_row_idx);
                res.row_sum   = mrcs_pkg::SUM_OUT_W'(lead_row_sum);
                res.col_index = mrcs_pkg::IDX_OUT_W'(lead_col_idx);
                res.col_sum   = mrcs_pkg::SUM_OUT_W'(lead_col_sum);
                argmax_q.push_back(res);
                restart_matrix();
            end else begin
                row_at = r + 1;
            end
        end else begin
            col_at = c + 1;
        end
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_elem(input t_fill style);
        case (style)
            VAL_TINY:    return ELEM_W'(int'($urandom_range(6)) - 3);
            VAL_EXTREME: return $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
            VAL_MIXED:   return ($urandom_range(3) == 0) ?
                                ($urandom_range(1) ? ELEM_MAX : ELEM_MIN) : ELEM_W'($urandom);
            default:     return ELEM_W'($urandom);
        endcase
    endfunction

    // Mostly small sizes, with zero and oversized values now and then.
    function automatic logic [mrcs_pkg::CFG_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) return mrcs_pkg::CFG_W'($urandom_range(1, 4));
        if (roll < 85) return mrcs_pkg::CFG_W'($urandom_range(5, MAX_DIM));
        if (roll < 92) return '0;
        return mrcs_pkg::CFG_W'($urandom_range(MAX_DIM + 1, (1 << mrcs_pkg::CFG_W) - 1));
    endfunction

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            n_errors++;
        end
    endtask

    task automatic write_reg(input logic [mrcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mrcs_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic push_elem(input logic signed [ELEM_W-1:0] value);
        elem_q.push_back(value);
        n_queued++;
    endtask

    // Waits until every queued word is taken and every argmax word is back,
    // then lets the pipeline settle. Returns just after a falling edge.
    task automatic drain();
        do @(negedge i_clk);
        while (n_accepted != n_queued || argmax_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Input side: tracks reset, register writes and accepted words.
    always @(posedge i_clk) begin : input_observer
        elem_taken = i_rst_n && src_valid && elem_if.ready;
        if (!i_rst_n) begin
            dim_rows = mrcs_pkg::CFG_DIM_RESET;
            dim_cols = mrcs_pkg::CFG_DIM_RESET;
            restart_matrix();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    mrcs_pkg::CFG_NUM_ROWS: begin
                        dim_rows = cfg_data;
                        restart_matrix();
                    end
                    mrcs_pkg::CFG_NUM_COLS: begin
                        dim_cols = cfg_data;
                        restart_matrix();
                    end
                    default: ;
                endcase
            end
            if (elem_taken) begin
                track_element(src_value);
                n_accepted++;
            end
        end
    end

    // Driver: presents the next word at the falling edge, idling at random.
    always @(negedge i_clk) begin : elem_driver
        logic                     next_valid;
        logic signed [ELEM_W-1:0] next_value;
        next_valid = src_valid;
        next_value = src_value;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!src_valid || elem_taken) begin
            if (elem_q.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
                next_valid = 1'b1;
                next_value = elem_q.pop_front();
            end else begin
                next_valid = 1'b0;
            end
        end
        src_valid <= next_valid;
        src_value <= next_value;
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(negedge i_clk) begin : res_receiver
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
        end else if (stall_req && !stall_done) begin
            stall_done = 1'b1;
            stall_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= quiet || $urandom_range(99) >= 13;
        end
    end

    // Monitor: compares each argmax word against the oldest prediction.
    always @(posedge i_clk) begin : res_monitor
        t_argmax want;
        if (i_rst_n && res_if.valid && rsp_ready) begin
            n_results++;
            if (argmax_q.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, got %0d/%0d %0d/%0d",
                         $time, res_if.best_row_index, res_if.best_row_sum,
                         res_if.best_col_index, res_if.best_col_sum);
                n_errors++;
            end else begin
                want = argmax_q.pop_front();
                check_field("best_row_index", want.row_index, res_if.best_row_index);
                check_field("best_row_sum", want.row_sum, res_if.best_row_sum);
                check_field("best_col_index", want.col_index, res_if.best_col_index);
                check_field("best_col_sum", want.col_sum, res_if.best_col_sum);
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin : watchdog
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("** matrix_max_row_col_sum: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int                              phase;
        int                              count;
        int                              size;
        int                              n_rand;
        t_fill                           style;
        logic [mrcs_pkg::CFG_IDX_W-1:0]  spare;
        phase  = 0;
        n_rand = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset sizes, every element at the minimum: all sums tie at the floor.
        @(posedge i_clk);
        repeat (MAX_DIM * MAX_DIM) push_elem(ELEM_MIN);
        drain();

        // Zero sizes act as one: each word is a whole matrix.
        write_reg(mrcs_pkg::CFG_NUM_ROWS, '0);
        write_reg(mrcs_pkg::CFG_NUM_COLS, '0);
        @(posedge i_clk);
        push_elem(ELEM_MAX);
        push_elem(ELEM_MIN);
        push_elem('0);
        push_elem(ELEM_W'(-1));
        drain();

        // Oversized row count clips to the maximum; the last row wins.
        write_reg(mrcs_pkg::CFG_NUM_ROWS, 5'd17);
        @(posedge i_clk);
        for (int r = 0; r < MAX_DIM; r++) push_elem(ELEM_W'(r));
        drain();

        // Ties go to index zero, then a matrix whose later row and column win.
        write_reg(mrcs_pkg::CFG_NUM_ROWS, 5'd2);
        write_reg(mrcs_pkg::CFG_NUM_COLS, 5'd3);
        @(posedge i_clk);
        repeat (6) push_elem(ELEM_W'(5));
        for (int k = 1; k <= 6; k++) push_elem(ELEM_W'(k));

        // A write to an unused index keeps the half-sent matrix.
        for (int k = 1; k <= 3; k++) push_elem(ELEM_W'(k));
        drain();
        write_reg(CFG_SPARE_A, 5'd9);
        @(posedge i_clk);
        for (int k = 4; k <= 6; k++) push_elem(ELEM_W'(k));
        push_elem(ELEM_W'(7));
        push_elem(ELEM_W'(8));

        // A real register write abandons the matrix in progress.
        drain();
        write_reg(mrcs_pkg::CFG_NUM_COLS, 5'd3);
        @(posedge i_clk);
        for (int k = 0; k < 6; k++) push_elem(ELEM_W'(k * 3 - 7));
        drain();

        // Full size with one row and one column at the maximum sum.
        write_reg(mrcs_pkg::CFG_NUM_ROWS, 5'd16);
        write_reg(mrcs_pkg::CFG_NUM_COLS, 5'd31);
        @(posedge i_clk);
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++)
                push_elem((r == 5 || c == 9) ? ELEM_MAX : pick_elem(VAL_ANY));
        drain();

        // Long receiver hold-off while single-element matrices keep coming.
        write_reg(mrcs_pkg::CFG_NUM_ROWS, 5'd1);
        write_reg(mrcs_pkg::CFG_NUM_COLS, 5'd1);
        @(posedge i_clk);
        stall_req = 1'b1;
        repeat (40) push_elem(pick_elem(VAL_MIXED));

        // Random phases: new sizes between phases, whole matrices mostly,
        // sometimes a trailing partial matrix or a short burst of noise.
        forever begin
            drain();
            if (n_rand >= RAND_ITEMS) break;
            if ($urandom_range(99) < 60) write_reg(mrcs_pkg::CFG_NUM_ROWS, pick_dim());
            if ($urandom_range(99) < 60) write_reg(mrcs_pkg::CFG_NUM_COLS, pick_dim());
            if ($urandom_range(99) < 15) begin
                spare = $urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B;
                write_reg(spare, mrcs_pkg::CFG_W'($urandom));
            end
            @(posedge i_clk);
            quiet = (phase >= 1 && phase <= 4);
            style = t_fill'($urandom_range(3));
            size  = clip_dim(dim_rows) * clip_dim(dim_cols);
            count = size * $urandom_range(1, (size > 40) ? 1 : 40 / size);
            if (size > 1 && $urandom_range(3) == 0) count += $urandom_range(1, size - 1);
            if ($urandom_range(19) == 0) count = $urandom_range(1, 6);
            repeat (count) push_elem(pick_elem(style));
            n_rand += count;
            phase++;
        end

        quiet = 1'b0;
        if (n_errors == 0) begin
            $display("** matrix_max_row_col_sum: PASSED **");
        end else begin
            $display("** matrix_max_row_col_sum: FAILED **");
        end
        $finish;
    end

endmodule
